>>> hdl/lpht_pkg.sv
package lpht_pkg;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_ABSENT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  localparam logic [1:0] CFG_KEY_BYTES   = 2'd0;
  localparam logic [1:0] CFG_VALUE_BYTES = 2'd1;
  localparam logic [1:0] CFG_MAX_ENTRIES = 2'd2;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;  // prime is 2^40 + 0x1b3

  function automatic logic [3:0] clamp_bytes(input logic [3:0] n, input logic [3:0] maxn);
    logic [3:0] m;
    m = (maxn < 4'd1) ? 4'd1 : ((maxn > 4'd8) ? 4'd8 : maxn);
    if (n < 4'd1) return 4'd1;
    if (n > m) return m;
    return n;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    for (int b = 0; b < 64; b++) begin
      m[b] = (7'(b) < {n[3:0], 3'b000});
    end
    return m;
  endfunction

  // one FNV-1a round: xor byte, multiply by the prime as shift plus a narrow product
  function automatic logic [63:0] fnv_round(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    logic [72:0] p;
    x = h ^ {56'd0, b};
    p = x * FNV_PRIME_LO;
    return (x << 40) + p[63:0];
  endfunction

endpackage

>>> hdl/linear_probe_hash_table_core.sv
// Channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-------------------------------------
// request  | in        | in_valid_i/in_stall_o | mode_i, key_i, value_i
// result   | out       | out_valid_o/out_stall_i | found_o, value_out_o, status_o,
//          |           |                       | entry_total_o
// config   | in        | cfg_we_i              | cfg_index_i, cfg_data_i
//
// Steps: front accepts, hashes one key byte a cycle, then enqueues. Back: pop, one slot
// probed a cycle over the single table RAM port, finish; remove walks the backward shift
// through S_DEL_RD and S_DEL_CHK for each slot, then frees the hole in S_DEL_END.
// Reset: a clearing pass over all 2^SLOT_BITS slots marks every slot free; requests stall.
// A waiting result is held in the output register; back stalls only at its finish.
module linear_probe_hash_table_core import lpht_pkg::*; #(
  parameter int SLOT_BITS   = 10,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [9:0]             cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             mode_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   found_o,
  output logic [VALUE_WIDTH-1:0] value_out_o,
  output logic [1:0]             status_o,
  output logic [10:0]            entry_total_o
);

  localparam int QW = 2 + KEY_WIDTH + VALUE_WIDTH + SLOT_BITS;

  // config registers
  logic [3:0] key_bytes_q, value_bytes_q;
  logic [9:0] max_entries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_q   <= 4'd8;
      value_bytes_q <= 4'd8;
      max_entries_q <= 10'd512;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KEY_BYTES:   key_bytes_q   <= cfg_data_i[3:0];
        CFG_VALUE_BYTES: value_bytes_q <= cfg_data_i[3:0];
        CFG_MAX_ENTRIES: max_entries_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective byte counts, clamped to the port widths
  logic [3:0]  kb, vb;
  logic [63:0] key_mask, value_mask;

  assign kb         = clamp_bytes(key_bytes_q, 4'(KEY_WIDTH / 8));
  assign vb         = clamp_bytes(value_bytes_q, 4'(VALUE_WIDTH / 8));
  assign key_mask   = byte_mask(kb);
  assign value_mask = byte_mask(vb);

  logic                   clearing, push, full, q_valid, pop;
  logic [1:0]             f_mode;
  logic [KEY_WIDTH-1:0]   f_key;
  logic [VALUE_WIDTH-1:0] f_value;
  logic [SLOT_BITS-1:0]   f_home;
  logic [QW-1:0]          q_data;

  lpht_front #(
    .SLOT_BITS(SLOT_BITS), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .hold_i      (clearing),
    .key_bytes_i (kb),
    .key_mask_i  (key_mask),
    .value_mask_i(value_mask),
    .push_o      (push),
    .full_i      (full),
    .mode_o      (f_mode),
    .key_o       (f_key),
    .value_o     (f_value),
    .home_o      (f_home)
  );

  // classified requests wait here while the back end walks the table
  lpht_queue #(.WIDTH(QW)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({f_mode, f_key, f_value, f_home}),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o (q_data)
  );

  lpht_back #(
    .SLOT_BITS(SLOT_BITS), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_pop_o       (pop),
    .mode_i        (q_data[QW-1 -: 2]),
    .key_i         (q_data[VALUE_WIDTH+SLOT_BITS +: KEY_WIDTH]),
    .value_i       (q_data[SLOT_BITS +: VALUE_WIDTH]),
    .home_i        (q_data[SLOT_BITS-1:0]),
    .key_mask_i    (key_mask),
    .max_entries_i (max_entries_q),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .value_out_o   (value_out_o),
    .status_o      (status_o),
    .entry_total_o (entry_total_o)
  );

endmodule

>>> hdl/lpht_ram.sv
module lpht_ram import lpht_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> hdl/lpht_queue.sv
module lpht_queue import lpht_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/lpht_front.sv
module lpht_front import lpht_pkg::*; #(
  parameter int SLOT_BITS   = 10,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             mode_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   hold_i,
  input  logic [3:0]             key_bytes_i,
  input  logic [63:0]            key_mask_i,
  input  logic [63:0]            value_mask_i,
  output logic                   push_o,
  input  logic                   full_i,
  output logic [1:0]             mode_o,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic [SLOT_BITS-1:0]   home_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HASH = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [63:0]            hash_q, hash_d;
  logic [1:0]             mode_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [63:0]            key_wide;
  logic                   take;

  assign in_stall_o = (state_q != S_IDLE) || hold_i;
  assign take       = in_valid_i && !in_stall_o;
  assign key_wide   = 64'(key_q);
  assign push_o     = (state_q == S_PUSH);
  assign mode_o     = mode_q;
  assign key_o      = key_q;
  assign value_o    = value_q;
  assign home_o     = hash_q[63 -: SLOT_BITS];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hash_d  = hash_q;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_HASH;
          cnt_d   = 3'd0;
          hash_d  = FNV_BASIS;
        end
      end
      S_HASH: begin
        hash_d = fnv_round(hash_q, 8'(key_wide >> {cnt_q, 3'b000}));
        cnt_d  = cnt_q + 3'd1;
        if ({1'b0, cnt_q} + 4'd1 == key_bytes_i) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!full_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    hash_q <= hash_d;
    if (take) begin
      mode_q  <= mode_i;
      key_q   <= key_i & key_mask_i[KEY_WIDTH-1:0];
      value_q <= value_i & value_mask_i[VALUE_WIDTH-1:0];
    end
  end

endmodule

>>> hdl/lpht_back.sv
module lpht_back import lpht_pkg::*; #(
  parameter int SLOT_BITS   = 10,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  logic [1:0]             mode_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [SLOT_BITS-1:0]   home_i,
  input  logic [63:0]            key_mask_i,
  input  logic [9:0]             max_entries_i,
  output logic                   clearing_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   found_o,
  output logic [VALUE_WIDTH-1:0] value_out_o,
  output logic [1:0]             status_o,
  output logic [10:0]            entry_total_o
);

  localparam int NSLOTS = 2 ** SLOT_BITS;
  localparam int WW     = 1 + SLOT_BITS + KEY_WIDTH + VALUE_WIDTH;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_PROBE   = 3'd2;
  localparam logic [2:0] S_FIN     = 3'd3;
  localparam logic [2:0] S_DEL_RD  = 3'd4;
  localparam logic [2:0] S_DEL_CHK = 3'd5;
  localparam logic [2:0] S_DEL_END = 3'd6;

  function automatic logic in_range(input logic [SLOT_BITS-1:0] i,
                                    input logic [SLOT_BITS-1:0] k,
                                    input logic [SLOT_BITS-1:0] j);
    if (i <= j) return (i < k) && (k <= j);
    return (i < k) || (k <= j);
  endfunction

  logic [2:0]             state_q, state_d;
  logic [SLOT_BITS-1:0]   clr_q, clr_d, idx_q, idx_d, hole_q, hole_d, j_q, j_d, jn;
  logic [SLOT_BITS:0]     steps_q, steps_d;
  logic [1:0]             mode_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [SLOT_BITS-1:0]   home_q;
  logic                   hit_q, hit_d, free_q, free_d;
  logic [WW-1:0]          hitw_q, hitw_d;
  logic [10:0]            count_q, count_d;
  logic                   ov_q, ov_d, found_q, found_d;
  logic [VALUE_WIDTH-1:0] vout_q, vout_d;
  logic [1:0]             status_q, status_d;

  logic                   we;
  logic [SLOT_BITS-1:0]   addr;
  logic [WW-1:0]          wdata, rdata;
  logic                   r_used;
  logic [SLOT_BITS-1:0]   r_home;
  logic [KEY_WIDTH-1:0]   r_key;
  logic [16:0]            limit;
  logic                   out_free, load;

  lpht_ram #(.WIDTH(WW), .DEPTH(NSLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign r_used   = rdata[WW-1];
  assign r_home   = rdata[KEY_WIDTH+VALUE_WIDTH +: SLOT_BITS];
  assign r_key    = rdata[VALUE_WIDTH +: KEY_WIDTH];
  assign limit    = (17'(max_entries_i) < 17'(NSLOTS)) ? 17'(max_entries_i) : 17'(NSLOTS);
  assign out_free = !ov_q || !out_stall_i;
  assign jn       = j_q + 1'b1;

  assign clearing_o    = (state_q == S_CLEAR);
  assign q_pop_o       = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o   = ov_q;
  assign found_o       = found_q;
  assign value_out_o   = vout_q;
  assign status_o      = status_q;
  assign entry_total_o = count_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    idx_d    = idx_q;
    steps_d  = steps_q;
    hole_d   = hole_q;
    j_d      = j_q;
    hit_d    = hit_q;
    free_d   = free_q;
    hitw_d   = hitw_q;
    count_d  = count_q;
    ov_d     = ov_q && out_stall_i;
    found_d  = found_q;
    vout_d   = vout_q;
    status_d = status_q;
    we       = 1'b0;
    addr     = idx_q;
    wdata    = '0;
    load     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        addr  = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == SLOT_BITS'(NSLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid_i) begin
          load    = 1'b1;
          addr    = home_i;
          idx_d   = home_i;
          steps_d = '0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!r_used) begin
          hit_d   = 1'b0;
          free_d  = 1'b1;
          state_d = S_FIN;
        end else if ((r_key & key_mask_i[KEY_WIDTH-1:0]) == key_q) begin
          hit_d   = 1'b1;
          free_d  = 1'b0;
          hitw_d  = rdata;
          state_d = S_FIN;
        end else if (steps_q == (SLOT_BITS+1)'(NSLOTS - 1)) begin
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q + 1'b1;
          addr    = idx_q + 1'b1;
          steps_d = steps_q + 1'b1;
        end
      end
      S_FIN: begin
        if (mode_q == MODE_REMOVE && hit_q) begin
          hole_d  = idx_q;
          j_d     = idx_q;
          state_d = S_DEL_RD;
        end else if (out_free) begin
          ov_d     = 1'b1;
          found_d  = hit_q;
          vout_d   = '0;
          status_d = STATUS_DONE;
          state_d  = S_IDLE;
          case (mode_q)
            MODE_INSERT: begin
              if (hit_q) begin
                we    = 1'b1;
                wdata = {hitw_q[WW-1:VALUE_WIDTH], value_q};
              end else if (17'(count_q) >= limit || !free_q) begin
                status_d = STATUS_FULL;
              end else begin
                we      = 1'b1;
                wdata   = {1'b1, home_q, key_q, value_q};
                count_d = count_q + 11'd1;
              end
            end
            MODE_REMOVE: status_d = STATUS_ABSENT;
            default: begin
              if (hit_q) vout_d = hitw_q[VALUE_WIDTH-1:0];
              else status_d = STATUS_ABSENT;
            end
          endcase
        end
      end
      S_DEL_RD: begin
        if (jn == hole_q) begin
          state_d = S_DEL_END;
        end else begin
          addr    = jn;
          j_d     = jn;
          state_d = S_DEL_CHK;
        end
      end
      S_DEL_CHK: begin
        state_d = S_DEL_RD;
        if (!r_used) begin
          state_d = S_DEL_END;
        end else if (!in_range(hole_q, r_home, j_q)) begin
          we     = 1'b1;
          addr   = hole_q;
          wdata  = rdata;
          hole_d = j_q;
        end
      end
      S_DEL_END: begin
        if (out_free) begin
          we       = 1'b1;
          addr     = hole_q;
          wdata    = '0;
          count_d  = (count_q != 11'd0) ? count_q - 11'd1 : count_q;
          ov_d     = 1'b1;
          found_d  = 1'b1;
          vout_d   = '0;
          status_d = STATUS_DONE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    steps_q  <= steps_d;
    hole_q   <= hole_d;
    j_q      <= j_d;
    hit_q    <= hit_d;
    free_q   <= free_d;
    hitw_q   <= hitw_d;
    found_q  <= found_d;
    vout_q   <= vout_d;
    status_q <= status_d;
    if (load) begin
      mode_q  <= mode_i;
      key_q   <= key_i;
      value_q <= value_i;
      home_q  <= home_i;
    end
  end

endmodule

>>> hdl/lpht_checker.sv
module lpht_checker import lpht_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic                   found_o,
  input logic [VALUE_WIDTH-1:0] value_out_o,
  input logic [1:0]             status_o,
  input logic [10:0]            entry_total_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(found_o) && $stable(value_out_o)
      && $stable(status_o) && $stable(entry_total_o))
    else $error("stalled result changed");

  a_absent_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_ABSENT || status_o == STATUS_FULL) |-> !found_o
      && value_out_o == '0)
    else $error("failed request reports a hit");

  a_value_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_out_o != '0 |-> found_o && status_o == STATUS_DONE)
    else $error("value returned without a hit");

endmodule

bind linear_probe_hash_table_core lpht_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .found_o      (found_o),
  .value_out_o  (value_out_o),
  .status_o     (status_o),
  .entry_total_o(entry_total_o)
);

>>> test/lpht_checker.sv
module lpht_scoreboard import lpht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        found_o,
  input  logic [63:0] value_out_o,
  input  logic [1:0]  status_o,
  input  logic [10:0] entry_total_o,
  output int          fail_count,
  output int          pending_count
);

  localparam int NSLOTS = 1024;

  typedef struct packed {
    logic        found;
    logic [63:0] value_out;
    logic [1:0]  status;
    logic [10:0] entry_total;
  } answer_t;

  logic [3:0]  key_bytes_q, value_bytes_q;
  logic [9:0]  max_entries_q;
  logic        used [NSLOTS];
  logic [63:0] skey [NSLOTS];
  logic [63:0] sval [NSLOTS];
  logic [9:0]  shome [NSLOTS];
  int unsigned held;
  answer_t     answers [$];

  function automatic int unsigned nbytes(logic [3:0] n);
    if (n == 0) return 1;
    if (n > 8) return 8;
    return n;
  endfunction

  function automatic logic [63:0] low_mask(int unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic logic [63:0] fnv64(logic [63:0] k, int unsigned n);
    logic [63:0] h;
    h = 64'hcbf29ce484222325;
    for (int i = 0; i < n; i++) begin
      h = h ^ ((k >> (8 * i)) & 64'hff);
      h = h * 64'h100000001b3;
    end
    return h;
  endfunction

  function automatic bit between(int unsigned i, int unsigned k, int unsigned j);
    if (i <= j) return i < k && k <= j;
    return i < k || k <= j;
  endfunction

  task automatic apply_request(logic [1:0] mode, logic [63:0] key_in, logic [63:0] val_in);
    int unsigned kb, vb, home, idx, lim, hole, j;
    logic [63:0] km, k, v;
    bit hit, free;
    answer_t a;
    kb = nbytes(key_bytes_q);
    vb = nbytes(value_bytes_q);
    km = low_mask(kb);
    k = key_in & km;
    v = val_in & low_mask(vb);
    home = 32'(fnv64(k, kb) >> 54);
    lim = max_entries_q;
    idx = home;
    hit = 0;
    free = 0;
    a = '0;
    for (int s = 0; s < NSLOTS; s++) begin
      if (!used[idx]) begin
        free = 1;
        break;
      end
      if ((skey[idx] & km) == k) begin
        hit = 1;
        break;
      end
      idx = (idx + 1) % NSLOTS;
    end
    a.found = hit;
    if (mode == MODE_INSERT) begin
      if (hit) begin
        sval[idx] = v;
      end else if (held >= lim || !free) begin
        a.status = STATUS_FULL;
      end else begin
        used[idx] = 1;
        skey[idx] = k;
        sval[idx] = v;
        shome[idx] = 10'(home);
        held++;
      end
    end else if (mode == MODE_REMOVE) begin
      if (!hit) begin
        a.status = STATUS_ABSENT;
      end else begin
        // backward shift keeps chains unbroken
        hole = idx;
        j = idx;
        for (int s = 0; s < NSLOTS; s++) begin
          j = (j + 1) % NSLOTS;
          if (j == hole || !used[j]) break;
          if (!between(hole, shome[j], j)) begin
            skey[hole] = skey[j];
            sval[hole] = sval[j];
            shome[hole] = shome[j];
            hole = j;
          end
        end
        used[hole] = 0;
        if (held > 0) held--;
      end
    end else begin
      if (hit) a.value_out = sval[idx];
      else a.status = STATUS_ABSENT;
    end
    a.entry_total = 11'(held);
    answers.push_back(a);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t w;
    if (!rst_ni) begin
      key_bytes_q <= 4'd8;
      value_bytes_q <= 4'd8;
      max_entries_q <= 10'd512;
      for (int i = 0; i < NSLOTS; i++) used[i] = 0;
      held = 0;
      answers.delete();
      fail_count = 0;
      pending_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_KEY_BYTES:   key_bytes_q <= cfg_data_i[3:0];
          CFG_VALUE_BYTES: value_bytes_q <= cfg_data_i[3:0];
          CFG_MAX_ENTRIES: max_entries_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) apply_request(mode_i, key_i, value_i);
      if (out_valid_o && !out_stall_i) begin
        if (answers.size() == 0) begin
          report("unexpected item", 0, 0);
        end else begin
          w = answers.pop_front();
          if (found_o !== w.found) report("found", found_o, w.found);
          if (value_out_o !== w.value_out) report("value_out", value_out_o, w.value_out);
          if (status_o !== w.status) report("status", status_o, w.status);
          if (entry_total_o !== w.entry_total)
            report("entry_total", entry_total_o, w.entry_total);
        end
      end
      pending_count = answers.size();
    end
  end

endmodule

>>> test/linear_probe_hash_table_core_test.sv
module linear_probe_hash_table_core_test import lpht_pkg::*;;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  mode;
  logic [63:0] key, value;
  logic        out_valid, out_stall;
  logic        found;
  logic [63:0] value_out;
  logic [1:0]  status;
  logic [10:0] entry_total;
  int          fail_count, pending_count;

  // idle odds in percent for each side; changed per phase
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned quiet_cycles;
  logic [63:0] key_pool [16];

  linear_probe_hash_table_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .key_i(key), .value_i(value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .found_o(found), .value_out_o(value_out), .status_o(status),
    .entry_total_o(entry_total)
  );

  lpht_scoreboard checker_inst (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .key_i(key), .value_i(value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .found_o(found), .value_out_o(value_out), .status_o(status),
    .entry_total_o(entry_total),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver stalls at random; decided at each edge
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // watchdog: cycles with no item accepted on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one request: optional idle gap, then hold valid until accepted
  task automatic send(logic [1:0] m, logic [63:0] k, logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    mode <= m;
    key <= k;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // mostly keys from a small pool so lookups and removes hit
  task automatic random_burst(int n);
    logic [1:0] m;
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      m = 2'($urandom_range(3));
      if ($urandom_range(99) < 80) k = key_pool[$urandom_range(15)];
      else k = {$urandom, $urandom};
      if ($urandom_range(99) < 15) k = k ^ ({$urandom, $urandom} << 32);
      send(m, k, {$urandom, $urandom});
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    mode = 0;
    key = 0;
    value = 0;
    out_stall = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every mode, overwrite, misses, mode 3
    send(MODE_LOOKUP, 64'd0, 64'd0);
    send(MODE_INSERT, 64'd0, 64'hffff_ffff_ffff_ffff);
    send(MODE_INSERT, '1, 64'h0123_4567_89ab_cdef);
    send(MODE_LOOKUP, 64'd0, 64'd0);
    send(MODE_LOOKUP, '1, 64'd0);
    send(MODE_INSERT, '1, 64'h5555_aaaa_5555_aaaa);
    send(2'd3, '1, '1);
    send(MODE_REMOVE, 64'd0, 64'd0);
    send(MODE_REMOVE, 64'd0, 64'd0);
    send(MODE_LOOKUP, 64'd0, 64'd0);
    send(MODE_REMOVE, '1, 64'd0);
    drain();

    // short widths: upper key bytes ignored, value masked, collisions plenty
    write_reg(CFG_KEY_BYTES, 10'd1);
    write_reg(CFG_VALUE_BYTES, 10'd1);
    write_reg(CFG_MAX_ENTRIES, 10'd3);
    send(MODE_INSERT, 64'h11, '1);
    send(MODE_INSERT, 64'h22, '1);
    send(MODE_INSERT, 64'hff33, '1);
    send(MODE_INSERT, 64'h44, '1);
    send(MODE_INSERT, 64'h1111, 64'h77);
    send(MODE_LOOKUP, 64'hab11, 64'd0);
    drain();

    // out-of-range widths act as limits; width change while keys held
    write_reg(CFG_KEY_BYTES, 10'd0);
    write_reg(CFG_VALUE_BYTES, 10'd15);
    write_reg(CFG_MAX_ENTRIES, 10'd0);
    send(MODE_INSERT, 64'h99, '1);
    send(MODE_LOOKUP, 64'h33, 64'd0);
    send(MODE_INSERT, 64'h22, 64'h1234);
    drain();
    write_reg(CFG_KEY_BYTES, 10'd9);
    write_reg(CFG_MAX_ENTRIES, 10'd1023);
    send(MODE_LOOKUP, 64'h22, 64'd0);
    drain();

    // random phases across settings and idle mixes
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_KEY_BYTES, 10'($urandom_range(9)));
      write_reg(CFG_VALUE_BYTES, 10'($urandom_range(9)));
      case (p % 4)
        0: write_reg(CFG_MAX_ENTRIES, 10'd1023);
        1: write_reg(CFG_MAX_ENTRIES, 10'd1);
        default: write_reg(CFG_MAX_ENTRIES, 10'($urandom_range(1, 40)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      random_burst(90);
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/lpht_pkg.sv
hdl/lpht_ram.sv
hdl/lpht_queue.sv
hdl/lpht_front.sv
hdl/lpht_back.sv
hdl/linear_probe_hash_table_core.sv
hdl/lpht_checker.sv
test/lpht_checker.sv
test/linear_probe_hash_table_core_test.sv
